FILE: rtl/gcb_pkg.sv
// Shared types, constants and the arctangent table for the bearing datapath.
package gcb_pkg;

   // CORDIC iteration count and datapath widths
   localparam int ITER = 30;
   localparam int AW   = 34;   // rotation x/y/z and angle accumulator width
   localparam int VW   = 37;   // vectoring x/y width

   // pi in Q60 and derived fixed-point constants
   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q30_W = (PI_Q60 + 64'h20000000) >> 30;
   localparam logic [31:0] PI_Q30   = PI_Q30_W[31:0];
   localparam logic [63:0] KDEG_W   = PI_Q60 / 64'd1800000000;
   localparam logic [31:0] KDEG     = KDEG_W[31:0];
   localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;

   // Angle turns in 1e-7 degree units
   localparam logic signed [33:0] FULL_TURN    = 34'sd3600000000;
   localparam logic signed [33:0] HALF_TURN    = 34'sd1800000000;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;

   // Compass sector of the target relative to the start
   typedef enum logic [3:0] {
      SEC_NE,
      SEC_SE,
      SEC_SW,
      SEC_NW,
      SEC_N,
      SEC_E,
      SEC_S,
      SEC_W,
      SEC_SAME
   } sector_type;

   // Classified request passed from front to back
   typedef struct packed {
      logic signed [30:0] lat1;
      logic               lat1_neg;
      logic signed [30:0] lat2;
      logic               lat2_neg;
      logic signed [30:0] dlon;
      logic               dlon_neg;
      sector_type         sector;
   } item_type;

   // atan(2^-idx) in Q30, rounded
   function automatic logic signed [AW-1:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0:       v = 32'd843314857;
         1:       v = 32'd497837829;
         2:       v = 32'd263043837;
         3:       v = 32'd133525159;
         4:       v = 32'd67021687;
         5:       v = 32'd33543516;
         6:       v = 32'd16775851;
         7:       v = 32'd8388437;
         8:       v = 32'd4194283;
         9:       v = 32'd2097149;
         default: v = 32'd1 << (30 - idx);
      endcase
      return AW'(v);
   endfunction

endpackage

FILE: rtl/great_circle_bearing.sv
// Great-circle initial bearing between two positions, top level.
//
// Request channel (req_*): start and target latitude/longitude, signed, in
// units of 1e-7 degree. A request is taken on a rising edge with req_valid
// high and req_stall low. Response channel (rsp_*): bearing clockwise from
// north in hundredths of a degree (0..35999) and a same_point flag, taken on
// a rising edge with rsp_valid high and rsp_stall low.
// Throughput: one request per cycle, sustained while rsp_stall stays low.
// Most of the path from request to response is the two 30-stage CORDIC
// pipelines (sine/cosine, then arctangent); the rest is angle reduction,
// the product stages and degree conversion.
// The front end classifies and reduces angles and writes a short queue; the
// back end reads it. When rsp_stall holds a response, the back end freezes,
// the queue fills and req_stall rises; nothing is dropped.
// Reset (synchronous) empties the pipeline and queue; no response is pending.
module great_circle_bearing #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_from_lat,
   input  logic signed [31:0] req_from_lon,
   input  logic signed [30:0] req_to_lat,
   input  logic signed [31:0] req_to_lon,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_bearing,
   output logic               rsp_same_point
);
   import gcb_pkg::*;

   item_type front_item;
   item_type head;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;

   gcb_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_from_lat(req_from_lat), .req_from_lon(req_from_lon),
      .req_to_lat(req_to_lat), .req_to_lon(req_to_lon),
      .fifo_full(full), .push(push), .item(front_item)
   );

   gcb_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .wr_item(front_item), .full(full),
      .pop(pop), .head(head), .empty(empty)
   );

   gcb_back u_back (
      .clock(clock), .reset(reset),
      .fifo_empty(empty), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bearing(rsp_bearing), .rsp_same_point(rsp_same_point)
   );

endmodule

FILE: rtl/gcb_front.sv
// Front end: accepts requests, classifies the sector and reduces the angles.
module gcb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [30:0]    req_from_lat,
   input  logic signed [31:0]    req_from_lon,
   input  logic signed [30:0]    req_to_lat,
   input  logic signed [31:0]    req_to_lon,
   input  logic                  fifo_full,
   output logic                  push,
   output gcb_pkg::item_type     item
);
   import gcb_pkg::*;

   logic              v_ff [4];
   logic              v_in [4];
   logic              adv;
   sector_type        sec_ff [4];
   sector_type        sec_in;
   logic signed [33:0] a0_ff [3];
   logic signed [33:0] a1_ff [3];
   logic signed [33:0] a2_ff [3];
   logic signed [30:0] a3_ff [3];
   logic              n3_ff [3];

   // Freeze the whole front while the last stage cannot hand off
   assign adv       = !(v_ff[3] && fifo_full);
   assign req_stall = !adv;
   assign push      = v_ff[3] && !fifo_full;

   // Classify the request by raw coordinate comparison
   always_comb begin
      if (req_to_lat == req_from_lat && req_to_lon == req_from_lon) begin
         sec_in = SEC_SAME;
      end else if (req_to_lon > req_from_lon) begin
         if (req_to_lat > req_from_lat)      sec_in = SEC_NE;
         else if (req_to_lat < req_from_lat) sec_in = SEC_SE;
         else                                sec_in = SEC_E;
      end else if (req_to_lon < req_from_lon) begin
         if (req_to_lat > req_from_lat)      sec_in = SEC_NW;
         else if (req_to_lat < req_from_lat) sec_in = SEC_SW;
         else                                sec_in = SEC_W;
      end else begin
         sec_in = (req_to_lat > req_from_lat) ? SEC_N : SEC_S;
      end
   end

   // Advance stage valids
   always_comb begin
      v_in[0] = adv ? req_valid : v_ff[0];
      for (int k = 1; k < 4; k++) begin
         v_in[k] = adv ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < 4; k++) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   // Angle reduction: remainder, wrap into (-180, 180], fold beyond +-90
   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff[0]  <= 34'(req_from_lat);
         a0_ff[1]  <= 34'(req_to_lat);
         a0_ff[2]  <= 34'(req_to_lon) - 34'(req_from_lon);
         sec_ff[0] <= sec_in;
         for (int k = 1; k < 4; k++) begin
            sec_ff[k] <= sec_ff[k-1];
         end
         for (int j = 0; j < 3; j++) begin
            if (a0_ff[j] >= FULL_TURN)       a1_ff[j] <= a0_ff[j] - FULL_TURN;
            else if (a0_ff[j] <= -FULL_TURN) a1_ff[j] <= a0_ff[j] + FULL_TURN;
            else                             a1_ff[j] <= a0_ff[j];

            if (a1_ff[j] > HALF_TURN)        a2_ff[j] <= a1_ff[j] - FULL_TURN;
            else if (a1_ff[j] <= -HALF_TURN) a2_ff[j] <= a1_ff[j] + FULL_TURN;
            else                             a2_ff[j] <= a1_ff[j];

            if (a2_ff[j] > QUARTER_TURN) begin
               a3_ff[j] <= 31'(a2_ff[j] - HALF_TURN);
               n3_ff[j] <= 1'b1;
            end else if (a2_ff[j] < -QUARTER_TURN) begin
               a3_ff[j] <= 31'(a2_ff[j] + HALF_TURN);
               n3_ff[j] <= 1'b1;
            end else begin
               a3_ff[j] <= 31'(a2_ff[j]);
               n3_ff[j] <= 1'b0;
            end
         end
      end
   end

   assign item.lat1     = a3_ff[0];
   assign item.lat1_neg = n3_ff[0];
   assign item.lat2     = a3_ff[1];
   assign item.lat2_neg = n3_ff[1];
   assign item.dlon     = a3_ff[2];
   assign item.dlon_neg = n3_ff[2];
   assign item.sector   = sec_ff[3];

endmodule

FILE: rtl/gcb_fifo.sv
// Short request queue between the front and back ends.
module gcb_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gcb_pkg::item_type wr_item,
   output logic              full,
   input  logic              pop,
   output gcb_pkg::item_type head,
   output logic              empty
);
   import gcb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

FILE: rtl/gcb_rot.sv
// Pipelined rotation CORDIC: sine and cosine of a reduced angle.
module gcb_rot (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [30:0]           ang,
   input  logic                         neg,
   output logic signed [gcb_pkg::AW-1:0] sin_out,
   output logic signed [gcb_pkg::AW-1:0] cos_out
);
   import gcb_pkg::*;

   logic [29:0]          mag;
   logic [60:0]          prod_ff;
   logic [60:0]          rsum;
   logic [30:0]          rad;
   logic                 sign_ff;
   logic                 neg_ff [ITER+2];
   logic signed [AW-1:0] x_ff [ITER+1];
   logic signed [AW-1:0] y_ff [ITER+1];
   logic signed [AW-1:0] z_ff [ITER+1];
   logic signed [AW-1:0] sin_ff;
   logic signed [AW-1:0] cos_ff;

   assign mag  = 30'((ang < 0) ? -ang : ang);
   assign rsum = prod_ff + 61'(32'h20000000);
   assign rad  = rsum[60:30];

   always_ff @(posedge clock) begin
      if (enable) begin
         // Convert 1e-7 degree to Q30 radians
         prod_ff   <= 61'(mag) * 61'(KDEG);
         sign_ff   <= ang[30];
         neg_ff[0] <= neg;
         for (int k = 1; k < ITER + 2; k++) begin
            neg_ff[k] <= neg_ff[k-1];
         end
         x_ff[0] <= AW'(GAIN_Q30);
         y_ff[0] <= '0;
         z_ff[0] <= sign_ff ? -AW'(rad) : AW'(rad);
         // One micro-rotation per stage
         for (int i = 0; i < ITER; i++) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
         end
         // Undo the 180 degree fold
         sin_ff <= neg_ff[ITER+1] ? -y_ff[ITER] : y_ff[ITER];
         cos_ff <= neg_ff[ITER+1] ? -x_ff[ITER] : x_ff[ITER];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

FILE: rtl/gcb_back.sv
// Back end: trig products, vectoring CORDIC, quadrant and degree conversion.
module gcb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              fifo_empty,
   input  gcb_pkg::item_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_bearing,
   output logic              rsp_same_point
);
   import gcb_pkg::*;

   localparam int TL = 2 * ITER + 13;   // depth of the final conversion stage
   localparam int QT = 2 * ITER + 8;    // depth of the clamped angle
   localparam int RS = 40;
   localparam logic [63:0] KR_W  = (64'd18000 << RS) / 64'(PI_Q30);
   localparam logic [32:0] PI_R  = 33'(PI_Q30);
   localparam logic [32:0] TPI_R = 33'(PI_Q30) << 1;
   localparam logic [30:0] HPI   = 31'(PI_Q30 >> 1);
   localparam logic signed [AW-1:0] HPI_Z = AW'(HPI);

   logic                 back_adv;
   logic                 vld_ff [1:TL];
   sector_type           sec_ff [1:TL];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          bearing_ff;
   logic                 same_ff;

   logic signed [AW-1:0] s1, c1, s2, c2, sd, cd;
   logic signed [2*AW-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [AW-1:0] cd_ff, num_ff, t2_ff;
   logic signed [AW:0]   den_raw_ff;
   logic signed [VW-1:0] num_abs_ff;
   logic signed [VW-1:0] vx_ff [ITER+1];
   logic signed [VW-1:0] vy_ff [ITER+1];
   logic signed [AW-1:0] vz_ff [ITER+1];
   logic                 zero_ff [ITER+1];
   logic [30:0]          xa_ff;
   logic [32:0]          r_ff;
   logic [47:0]          n1_ff, n2_ff, n3_ff;
   logic [55:0]          pk_ff;
   logic [15:0]          qe2_ff, qe3_ff;
   logic [47:0]          m_ff;
   logic [47:0]          rem;
   logic [16:0]          q4_ff;
   logic [16:0]          qw;

   // Hold everything while a finished result waits
   assign back_adv     = !rsp_valid_ff || !rsp_stall;
   assign pop          = back_adv && !fifo_empty;
   assign rsp_valid_in = back_adv ? vld_ff[TL] : rsp_valid_ff;

   gcb_rot u_rot_lat1 (
      .clock(clock), .enable(back_adv), .ang(head.lat1), .neg(head.lat1_neg),
      .sin_out(s1), .cos_out(c1)
   );
   gcb_rot u_rot_lat2 (
      .clock(clock), .enable(back_adv), .ang(head.lat2), .neg(head.lat2_neg),
      .sin_out(s2), .cos_out(c2)
   );
   gcb_rot u_rot_dlon (
      .clock(clock), .enable(back_adv), .ang(head.dlon), .neg(head.dlon_neg),
      .sin_out(sd), .cos_out(cd)
   );

   // Valid and sector tags alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= TL; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (back_adv) begin
            vld_ff[1] <= pop;
            for (int k = 2; k <= TL; k++) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (back_adv) begin
         sec_ff[1] <= head.sector;
         for (int k = 2; k <= TL; k++) begin
            sec_ff[k] <= sec_ff[k-1];
         end
      end
   end

   assign rem = n3_ff - m_ff;
   assign qw  = (q4_ff >= 17'd36000) ? q4_ff - 17'd36000 : q4_ff;

   always_ff @(posedge clock) begin
      if (back_adv) begin
         // Numerator and denominator products
         p1_ff <= (2*AW)'(sd) * (2*AW)'(c2);
         p2_ff <= (2*AW)'(c1) * (2*AW)'(s2);
         p3_ff <= (2*AW)'(s1) * (2*AW)'(c2);
         cd_ff <= cd;
         num_ff <= $signed(p1_ff[30+AW-1:30]);
         t2_ff  <= $signed(p2_ff[30+AW-1:30]);
         p4_ff  <= (2*AW)'($signed(p3_ff[30+AW-1:30])) * (2*AW)'(cd_ff);
         den_raw_ff <= (AW+1)'(t2_ff) - (AW+1)'($signed(p4_ff[30+AW-1:30]));
         num_abs_ff <= (num_ff < 0) ? -VW'(num_ff) : VW'(num_ff);

         // Vectoring CORDIC seed
         vx_ff[0]   <= (den_raw_ff < 0) ? -VW'(den_raw_ff) : VW'(den_raw_ff);
         vy_ff[0]   <= num_abs_ff;
         vz_ff[0]   <= '0;
         zero_ff[0] <= (den_raw_ff == 0) && (num_abs_ff == 0);
         for (int i = 0; i < ITER; i++) begin
            zero_ff[i+1] <= zero_ff[i];
            if (vy_ff[i] > 0) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + atan_q30(i);
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - atan_q30(i);
            end
         end

         // Clamp into [0, pi/2]
         if (zero_ff[ITER] || vz_ff[ITER] < 0) xa_ff <= '0;
         else if (vz_ff[ITER] > HPI_Z)         xa_ff <= HPI;
         else                                  xa_ff <= 31'(vz_ff[ITER]);

         // Place the angle in its quadrant
         case (sec_ff[QT])
            SEC_NE:  r_ff <= 33'(xa_ff);
            SEC_SE:  r_ff <= PI_R - 33'(xa_ff);
            SEC_SW:  r_ff <= PI_R + 33'(xa_ff);
            SEC_NW:  r_ff <= TPI_R - 33'(xa_ff);
            default: r_ff <= '0;
         endcase

         // Radians to hundredths of a degree by reciprocal and correction
         n1_ff  <= 48'(r_ff) * 48'd18000 + 48'(PI_Q30 >> 1);
         pk_ff  <= 56'(r_ff) * 56'(KR_W);
         n2_ff  <= n1_ff;
         qe2_ff <= pk_ff[RS+15:RS];
         n3_ff  <= n2_ff;
         qe3_ff <= qe2_ff;
         m_ff   <= 48'(qe2_ff) * 48'(PI_Q30);
         if (rem >= 48'(TPI_R))      q4_ff <= 17'(qe3_ff) + 17'd2;
         else if (rem >= 48'(PI_R))  q4_ff <= 17'(qe3_ff) + 17'd1;
         else                        q4_ff <= 17'(qe3_ff);

         // Select axis, same-point or computed bearing
         same_ff <= (sec_ff[TL] == SEC_SAME);
         unique case (sec_ff[TL]) inside
            SEC_N, SEC_SAME: bearing_ff <= 16'd0;
            SEC_E:           bearing_ff <= 16'd9000;
            SEC_S:           bearing_ff <= 16'd18000;
            SEC_W:           bearing_ff <= 16'd27000;
            default:         bearing_ff <= qw[15:0];
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bearing    = bearing_ff;
   assign rsp_same_point = same_ff;

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bearing < 16'd36000)
      else $error("bearing out of range");

   a_same_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_same_point) |-> rsp_bearing == 16'd0)
      else $error("same point with nonzero bearing");

endmodule
